/* rtl/ts_pkg.sv */
package ts_pkg;

  // Field widths fixed by the interface.
  localparam int FIT_W      = 32;
  localparam int ENT_W      = 32;
  localparam int OFF_W      = 8;
  localparam int DRAW_W     = 16;
  localparam int PRESS_W    = 17;
  localparam int PICK_W     = 9;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam int MAX_CANDIDATES_DEF = 256;

  // Smallest tournament and the Q16 value of one.
  localparam logic [PICK_W-1:0]  MIN_TSIZE  = PICK_W'(2);
  localparam logic [PRESS_W-1:0] PRESS_ONE  = PRESS_W'(65536);

  // Reset values of the configuration registers.
  localparam logic [PICK_W-1:0]  TSIZE_RST  = PICK_W'(2);
  localparam logic [PRESS_W-1:0] PRESS_RST  = PRESS_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TSIZE    = 2'd0,
    CFG_REPL     = 2'd1,
    CFG_HIB      = 2'd2,
    CFG_PRESSURE = 2'd3
  } ts_cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_LOAD   = 2'd1,
    MODE_PICK   = 2'd2,
    MODE_DECIDE = 2'd3
  } ts_mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_EXTRA_PICK = 3'd3,
    ST_INCOMPLETE = 3'd4,
    ST_CLAMPED    = 3'd5
  } ts_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PERM,
    S_FIT,
    S_ENT
  } ts_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic perm;
    logic fit;
    logic ent;
    logic finish;
  } ts_cmd_t;

  // Datapath to controller, valid while the captured item is being executed.
  typedef struct packed {
    ts_mode_t mode;
    logic     empty;
    logic     over;
    logic     decide_ready;
    logic     with_repl;
  } ts_stat_t;

endpackage

/* rtl/ts_ctrl.sv */
module ts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ts_pkg::ts_stat_t  stat,
  output ts_pkg::ts_cmd_t   cmd,
  output logic              busy,
  output logic              done
);

  ts_pkg::ts_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ts_pkg::S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ts_pkg::S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ts_pkg::S_EXEC;
        end
      end
      ts_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        unique case (stat.mode) inside
          ts_pkg::MODE_CLEAR, ts_pkg::MODE_LOAD: begin
            cmd.finish = 1'b1;
            state_next = ts_pkg::S_IDLE;
          end
          ts_pkg::MODE_PICK: begin
            if (stat.empty || stat.over) begin
              cmd.finish = 1'b1;
              state_next = ts_pkg::S_IDLE;
            end else if (stat.with_repl) begin
              state_next = ts_pkg::S_FIT;
            end else begin
              state_next = ts_pkg::S_PERM;
            end
          end
          ts_pkg::MODE_DECIDE: begin
            if (!stat.empty && stat.decide_ready) begin
              state_next = ts_pkg::S_ENT;
            end else begin
              cmd.finish = 1'b1;
              state_next = ts_pkg::S_IDLE;
            end
          end
        endcase
      end
      ts_pkg::S_PERM: begin
        cmd.perm   = 1'b1;
        state_next = ts_pkg::S_FIT;
      end
      ts_pkg::S_FIT: begin
        cmd.fit    = 1'b1;
        cmd.finish = 1'b1;
        state_next = ts_pkg::S_IDLE;
      end
      ts_pkg::S_ENT: begin
        cmd.ent    = 1'b1;
        cmd.finish = 1'b1;
        state_next = ts_pkg::S_IDLE;
      end
      default: begin
        state_next = ts_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state != ts_pkg::S_IDLE);

endmodule

/* rtl/ts_dp.sv */
module ts_dp #(
  parameter int MAX_CANDIDATES = ts_pkg::MAX_CANDIDATES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ts_pkg::ts_cmd_t                 cmd,
  output ts_pkg::ts_stat_t                stat,
  input  logic [1:0]                      mode,
  input  logic [ts_pkg::FIT_W-1:0]        fitness,
  input  logic [ts_pkg::ENT_W-1:0]        entity_id,
  input  logic [ts_pkg::OFF_W-1:0]        pick_offset,
  input  logic [ts_pkg::DRAW_W-1:0]       pressure_draw,
  input  logic                            cfg_we,
  input  logic [ts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ts_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic [ts_pkg::STATUS_W-1:0]     status,
  output logic                            winner_valid,
  output logic [ts_pkg::ENT_W-1:0]        winner_entity,
  output logic [ts_pkg::PICK_W-1:0]       picks_needed
);

  localparam int IDX_W = $clog2(MAX_CANDIDATES);
  localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
  localparam int AW    = (CNT_W > ts_pkg::PICK_W) ? CNT_W : ts_pkg::PICK_W;
  localparam logic [AW-1:0] MAX_A = AW'(MAX_CANDIDATES);

  // Configuration registers.
  logic [ts_pkg::PICK_W-1:0]  tsize;
  logic                       with_repl;
  logic                       hib;
  logic [ts_pkg::PRESS_W-1:0] pressure;

  // Captured item.
  ts_pkg::ts_mode_t           mode_r;
  logic [ts_pkg::FIT_W-1:0]   fit_r;
  logic [ts_pkg::ENT_W-1:0]   ent_r;
  logic [ts_pkg::OFF_W-1:0]   off_r;
  logic [ts_pkg::DRAW_W-1:0]  draw_r;

  // Tournament state.
  logic [CNT_W-1:0]           loaded;
  logic [ts_pkg::PICK_W-1:0]  picks_done;
  logic [IDX_W-1:0]           best_idx;
  logic [ts_pkg::FIT_W-1:0]   best_fit;
  logic                       best_pres;
  logic [IDX_W-1:0]           second_idx;
  logic [ts_pkg::FIT_W-1:0]   second_fit;
  logic                       second_pres;
  logic [MAX_CANDIDATES-1:0]  perm_valid;
  logic [IDX_W-1:0]           swp_r;
  logic [IDX_W-1:0]           idx_r;
  logic                       clamp_r;

  // Memories.
  logic [ts_pkg::FIT_W-1:0] fit_mem  [MAX_CANDIDATES];
  logic [ts_pkg::ENT_W-1:0] ent_mem  [MAX_CANDIDATES];
  logic [IDX_W-1:0]         perm_mem [MAX_CANDIDATES];
  logic [ts_pkg::FIT_W-1:0] fit_rd;
  logic [ts_pkg::ENT_W-1:0] ent_rd;
  logic [IDX_W-1:0]         perm_rd0;
  logic [IDX_W-1:0]         perm_rd1;

  // Derived values.
  logic [AW-1:0]    loaded_a, picks_a, kk_a, k_a, lim_a, off_a, offc_a, swp_a;
  logic [IDX_W-1:0] pos_idx, last_idx, offc_idx, swp_idx;
  logic             clamp_c, take_best;
  logic [IDX_W-1:0] win_idx, win_clamped;
  logic [IDX_W-1:0] perm_a, perm_i, perm_i_clamped;
  logic [IDX_W-1:0] fit_raddr;
  logic             perm_we;
  logic [IDX_W-1:0] perm_waddr, perm_wdata;
  logic             load_ok;
  logic             beat_best, beat_second;
  logic [ts_pkg::STATUS_W-1:0] status_next;

  function automatic logic fit_beats(input logic h, input logic [IDX_W-1:0] ia,
                                     input logic [ts_pkg::FIT_W-1:0] fa,
                                     input logic [IDX_W-1:0] ib,
                                     input logic [ts_pkg::FIT_W-1:0] fb);
    logic r;
    if (fa != fb) begin
      r = h ? ($signed(fa) > $signed(fb)) : ($signed(fa) < $signed(fb));
    end else begin
      r = (ia < ib);
    end
    return r;
  endfunction

  always_comb begin
    loaded_a = AW'(loaded);
    picks_a  = AW'(picks_done);
    pos_idx  = picks_a[IDX_W-1:0];
    last_idx = IDX_W'(loaded_a - AW'(1));
    kk_a     = (tsize < ts_pkg::MIN_TSIZE) ? AW'(ts_pkg::MIN_TSIZE) : AW'(tsize);
    if (loaded_a == '0) begin
      k_a = '0;
    end else begin
      k_a = (kk_a > loaded_a) ? loaded_a : kk_a;
    end

    // Offset saturation for a pick.
    lim_a    = with_repl ? (loaded_a - AW'(1)) : (loaded_a - AW'(1) - picks_a);
    off_a    = AW'(off_r);
    clamp_c  = (off_a > lim_a);
    offc_a   = clamp_c ? lim_a : off_a;
    offc_idx = offc_a[IDX_W-1:0];
    swp_a    = picks_a + offc_a;
    swp_idx  = swp_a[IDX_W-1:0];

    // Winner choice for a decide.
    take_best   = pressure[ts_pkg::PRESS_W-1] ||
                  (ts_pkg::PRESS_W'(draw_r) <= pressure);
    win_idx     = (take_best || !second_pres) ? best_idx : second_idx;
    win_clamped = (AW'(win_idx) >= loaded_a) ? last_idx : win_idx;

    // Permutation entries: an entry not written this tournament is the identity.
    perm_a         = perm_valid[pos_idx] ? perm_rd0 : pos_idx;
    perm_i         = perm_valid[swp_r] ? perm_rd1 : swp_r;
    perm_i_clamped = (AW'(perm_i) >= loaded_a) ? last_idx : perm_i;

    fit_raddr = cmd.perm ? perm_i_clamped : offc_idx;

    // One write a cycle: the swap target first, the pick position after.
    perm_we    = cmd.perm || (cmd.fit && !with_repl);
    perm_waddr = cmd.perm ? swp_r : pos_idx;
    perm_wdata = cmd.perm ? perm_a : idx_r;

    load_ok = (loaded_a < MAX_A);

    beat_best   = !best_pres || fit_beats(hib, idx_r, fit_rd, best_idx, best_fit);
    beat_second = !second_pres || fit_beats(hib, idx_r, fit_rd, second_idx, second_fit);

    status_next = ts_pkg::ST_OK;
    if (cmd.exec) begin
      unique case (mode_r)
        ts_pkg::MODE_CLEAR:  status_next = ts_pkg::ST_OK;
        ts_pkg::MODE_LOAD:   status_next = load_ok ? ts_pkg::ST_OK : ts_pkg::ST_FULL;
        ts_pkg::MODE_PICK: begin
          if (loaded_a == '0) begin
            status_next = ts_pkg::ST_EMPTY;
          end else begin
            status_next = ts_pkg::ST_EXTRA_PICK;
          end
        end
        ts_pkg::MODE_DECIDE: begin
          if (loaded_a == '0) begin
            status_next = ts_pkg::ST_EMPTY;
          end else begin
            status_next = ts_pkg::ST_INCOMPLETE;
          end
        end
      endcase
    end else if (cmd.fit) begin
      status_next = clamp_r ? ts_pkg::ST_CLAMPED : ts_pkg::ST_OK;
    end

    stat.mode         = mode_r;
    stat.empty        = (loaded_a == '0);
    stat.over         = (picks_a >= k_a);
    stat.decide_ready = (picks_a >= k_a) && best_pres;
    stat.with_repl    = with_repl;
  end

  assign picks_needed = k_a[ts_pkg::PICK_W-1:0];

  // Item capture and scratch registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= ts_pkg::ts_mode_t'(mode);
      fit_r  <= fitness;
      ent_r  <= entity_id;
      off_r  <= pick_offset;
      draw_r <= pressure_draw;
    end
    if (cmd.exec) begin
      swp_r   <= swp_idx;
      idx_r   <= offc_idx;
      clamp_r <= clamp_c;
    end
    if (cmd.perm) begin
      idx_r <= perm_i_clamped;
    end
  end

  // Candidate stores.
  always_ff @(posedge clk) begin
    if (cmd.exec && (mode_r == ts_pkg::MODE_LOAD) && load_ok) begin
      fit_mem[loaded_a[IDX_W-1:0]] <= fit_r;
      ent_mem[loaded_a[IDX_W-1:0]] <= ent_r;
    end
    fit_rd <= fit_mem[fit_raddr];
    ent_rd <= ent_mem[win_clamped];
  end

  // Index permutation store.
  always_ff @(posedge clk) begin
    if (perm_we) begin
      perm_mem[perm_waddr] <= perm_wdata;
    end
    perm_rd0 <= perm_mem[pos_idx];
    perm_rd1 <= perm_mem[swp_idx];
  end

  // Control state, configuration and results.
  always_ff @(posedge clk) begin
    if (rst) begin
      tsize         <= ts_pkg::TSIZE_RST;
      with_repl     <= 1'b1;
      hib           <= 1'b1;
      pressure      <= ts_pkg::PRESS_RST;
      loaded        <= '0;
      picks_done    <= '0;
      best_idx      <= '0;
      best_fit      <= '0;
      best_pres     <= 1'b0;
      second_idx    <= '0;
      second_fit    <= '0;
      second_pres   <= 1'b0;
      perm_valid    <= '0;
      status        <= ts_pkg::ST_OK;
      winner_valid  <= 1'b0;
      winner_entity <= '0;
    end else begin
      if (cfg_we) begin
        unique case (ts_pkg::ts_cfg_idx_t'(cfg_index))
          ts_pkg::CFG_TSIZE:    tsize     <= cfg_data[ts_pkg::PICK_W-1:0];
          ts_pkg::CFG_REPL:     with_repl <= cfg_data[0];
          ts_pkg::CFG_HIB:      hib       <= cfg_data[0];
          ts_pkg::CFG_PRESSURE: pressure  <= cfg_data[ts_pkg::PRESS_W-1:0];
        endcase
      end

      if (cmd.exec && (mode_r == ts_pkg::MODE_LOAD) && load_ok) begin
        loaded <= loaded + CNT_W'(1);
      end

      if (cmd.perm) begin
        perm_valid[swp_r] <= 1'b1;
      end

      if (cmd.fit) begin
        if (!with_repl) begin
          perm_valid[pos_idx] <= 1'b1;
        end
        if (beat_best) begin
          second_idx  <= best_idx;
          second_fit  <= best_fit;
          second_pres <= best_pres;
          best_idx    <= idx_r;
          best_fit    <= fit_rd;
          best_pres   <= 1'b1;
        end else if (beat_second) begin
          second_idx  <= idx_r;
          second_fit  <= fit_rd;
          second_pres <= 1'b1;
        end
        picks_done <= picks_done + ts_pkg::PICK_W'(1);
      end

      // Clear and a completed decide both restart the tournament.
      if ((cmd.exec && (mode_r == ts_pkg::MODE_CLEAR)) || cmd.ent) begin
        if (cmd.exec) begin
          loaded <= '0;
        end
        picks_done  <= '0;
        best_idx    <= '0;
        best_fit    <= '0;
        best_pres   <= 1'b0;
        second_idx  <= '0;
        second_fit  <= '0;
        second_pres <= 1'b0;
        perm_valid  <= '0;
      end

      if (cmd.finish) begin
        status        <= status_next;
        winner_valid  <= cmd.ent;
        winner_entity <= cmd.ent ? ent_rd : '0;
      end
    end
  end

endmodule

/* rtl/tournament_selector.sv */
// Tournament selector for a genetic algorithm. Load candidates (signed Q16.16
// fitness plus a 32-bit entity id) with load items, run a tournament with pick
// items that each carry a random offset already reduced to range, and finish
// it with a decide item that returns the best or the second-best picked
// candidate according to the Q16 selection pressure. Every accepted item
// produces exactly one result beat: the result ports are valid for the single
// cycle in which done is high, and the receiver cannot stall them, so it must
// take every beat in that cycle. An item is accepted on a clock edge where
// start is high and busy is low. Clear, load and refused items end in the
// execute state; a pick with replacement goes on to the fitness state and a
// decide that names a winner to the entity state; a pick without replacement
// passes the permutation state first. The extra states come from the candidate
// memories, whose reads are registered, and from the index permutation memory,
// which is read at two addresses in one cycle but written at one address per
// cycle, so the swap of a unique pick is split over the permutation and
// fitness states. busy drops in the cycle that shows the result, so the next
// item can be accepted there. Configuration writes are taken at any time on
// the cfg channel, but should only be issued while the block is idle.

module tournament_selector #(
  parameter int MAX_CANDIDATES = ts_pkg::MAX_CANDIDATES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,

  // Item command channel.
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      mode,
  input  logic [ts_pkg::FIT_W-1:0]        fitness,
  input  logic [ts_pkg::ENT_W-1:0]        entity_id,
  input  logic [ts_pkg::OFF_W-1:0]        pick_offset,
  input  logic [ts_pkg::DRAW_W-1:0]       pressure_draw,

  // Result beat, one per item.
  output logic                            done,
  output logic [ts_pkg::STATUS_W-1:0]     status,
  output logic                            winner_valid,
  output logic [ts_pkg::ENT_W-1:0]        winner_entity,
  output logic [ts_pkg::PICK_W-1:0]       picks_needed,

  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ts_pkg::CFG_DATA_W-1:0]   cfg_data
);

  ts_pkg::ts_cmd_t  cmd;
  ts_pkg::ts_stat_t stat;

  // The register file is always able to take a write.
  assign cfg_ready = 1'b1;

  // The controller sequences each item through its states; the datapath owns
  // the memories, the tournament state and the result registers.
  ts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  ts_dp #(
    .MAX_CANDIDATES (MAX_CANDIDATES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .mode          (mode),
    .fitness       (fitness),
    .entity_id     (entity_id),
    .pick_offset   (pick_offset),
    .pressure_draw (pressure_draw),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .status        (status),
    .winner_valid  (winner_valid),
    .winner_entity (winner_entity),
    .picks_needed  (picks_needed)
  );

endmodule

/* rtl/ts_checker.sv */
module ts_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [ts_pkg::STATUS_W-1:0]   status,
  input logic                          winner_valid,
  input logic [ts_pkg::ENT_W-1:0]      winner_entity
);

  // An accepted item always makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  // A result beat only follows work in progress.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without preceding work");

  // A winner is only reported with a clean status.
  a_winner_status: assert property (@(posedge clk) disable iff (rst)
    (done && winner_valid) |-> (status == ts_pkg::ST_OK))
    else $error("winner reported with a nonzero status");

  // Without a winner the entity field reads zero.
  a_no_winner_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !winner_valid) |-> (winner_entity == '0))
    else $error("entity nonzero on a beat without a winner");

  // Leaving reset, the block is idle and shows no beat.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !done))
    else $error("block not idle after reset");

endmodule

bind tournament_selector ts_checker u_ts_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .status        (status),
  .winner_valid  (winner_valid),
  .winner_entity (winner_entity)
);
